// ===== rtl/circular_fifo_queue_macros.svh =====
// assertion helpers used by circular_fifo_queue.sv
`ifndef CIRCULAR_FIFO_QUEUE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CFQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CFQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/cfq_pkg.sv =====
package cfq_pkg;

  localparam int DEPTH = 256;
  // the cell chain holds one cell fewer than DEPTH
  localparam int CELLS = DEPTH - 1;
  localparam int CNT_W = $clog2(DEPTH);
  localparam int OCC_W = 8;
  localparam int EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_CLR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } cell_ctl_t;

  function automatic logic [OCC_W-1:0] sat_occ(input logic [CNT_W-1:0] cnt);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(cnt);
    sat_occ = (ext > EXT_W'(255)) ? {OCC_W{1'b1}} : ext[OCC_W-1:0];
  endfunction

endpackage

// ===== rtl/cfq_cell.sv =====
module cfq_cell
  import cfq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] push_value,
  input  logic              left_valid,
  input  logic              right_valid,
  input  logic [WORD_W-1:0] right_data,
  output logic              valid_o,
  output logic [WORD_W-1:0] data_o
);

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    priority if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (ctl.load && left_valid && !valid_r) begin
      // first free cell behind the occupied run takes the word
      valid_nxt = 1'b1;
      data_nxt  = push_value;
    end else begin
      valid_nxt = valid_r;
      data_nxt  = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== rtl/cfq_chain.sv =====
module cfq_chain
  import cfq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] push_value,
  output logic              head_valid,
  output logic [WORD_W-1:0] head_data
);

  // one extra position past the tail end that always reads as empty
  logic [CELLS:0]    valid_w;
  logic [WORD_W-1:0] data_w [CELLS+1];

  assign valid_w[CELLS] = 1'b0;
  assign data_w[CELLS]  = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic left_v;
    if (i == 0) begin : g_first
      assign left_v = 1'b1;
    end else begin : g_rest
      assign left_v = valid_w[i-1];
    end

    cfq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .push_value  (push_value),
      .left_valid  (left_v),
      .right_valid (valid_w[i+1]),
      .right_data  (data_w[i+1]),
      .valid_o     (valid_w[i]),
      .data_o      (data_w[i])
    );
  end

  assign head_valid = valid_w[0];
  assign head_data  = data_w[0];

endmodule

// ===== rtl/circular_fifo_queue.sv =====
// the result of an item is registered and is on out_* in the cycle after its input transfer
// throughput: one item per cycle unless the output stalls; each cell shifts or loads on an accept and
//   one output register separates the two sides, so input stalls only while that register holds an untaken result
// reset: synchronous active-low rst_n empties every cell, zeroes the occupancy
//   and drops out_tvalid; stored words are not cleared
`include "circular_fifo_queue_macros.svh"

module circular_fifo_queue
  import cfq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] head_value, [39:32] occupancy,
                                  // [40] is_empty, [41] is_full, [47:42] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic              accept;
  opcode_t           op;
  cell_ctl_t         ctl;
  logic              head_valid;
  logic [WORD_W-1:0] head_data;
  logic              is_full_now, is_empty_now;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [WORD_W-1:0] value_r, value_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              empty_r, empty_nxt;
  logic              full_r, full_nxt;

  assign in_tready    = !out_valid_r || out_tready;
  assign accept       = in_tvalid && in_tready;
  assign op           = opcode_t'(in_tuser);
  assign is_full_now  = (count_r == CNT_W'(DEPTH - 1));
  assign is_empty_now = (count_r == '0);

  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    value_nxt  = '0;
    unique case (op)
      OP_ENQ: begin
        if (is_full_now) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.load  = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (is_empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.shift = accept;
          value_nxt = head_data;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (is_empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          value_nxt = head_data;
        end
      end
      OP_CLR: begin
        ctl.clear = accept;
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    occ_nxt   = sat_occ(count_nxt);
    empty_nxt = (count_nxt == '0);
    full_nxt  = (count_nxt == CNT_W'(DEPTH - 1));
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  cfq_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .push_value (in_tdata),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      occ_r    <= occ_nxt;
      empty_r  <= empty_nxt;
      full_r   <= full_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'b0, full_r, empty_r, occ_r, value_r};

  `CFQ_ASSERT_ALWAYS(a_head_matches_count, head_valid == (count_r != '0), "head cell disagrees with count")
  `CFQ_ASSERT_ALWAYS(a_one_cell_cmd, $onehot0({ctl.shift, ctl.load, ctl.clear}), "conflicting cell commands")
  `CFQ_ASSERT_NEXT(a_enq_counts, accept && op == OP_ENQ && !is_full_now, count_r == $past(count_r) + CNT_W'(1), "enqueue did not bump count")
  `CFQ_ASSERT_NEXT(a_clear_empties, accept && op == OP_CLR, !head_valid && count_r == '0, "clear left entries behind")

endmodule
